@@ src/ame_pkg.sv @@
// Shared types, constants and helpers for the adjacency matrix engine.
package ame_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VALUE_BITS   = 8;
  localparam int VERTEX_BITS  = $clog2(MAX_VERTICES);
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_BITS    = $clog2(DEPTH);
  localparam int VC_BITS      = $clog2(MAX_VERTICES + 1);
  localparam int COUNT_BITS   = $clog2(DEPTH + 1);
  localparam int CFG_BITS     = 5;
  localparam int KIND_BITS    = 3;

  // Request kinds
  localparam logic [KIND_BITS-1:0] KIND_ADD      = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_READ     = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_NEIGHBOR = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_IN       = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_OUT      = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_COUNT    = 3'd6;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [VERTEX_BITS-1:0] from_vertex;
    logic [VERTEX_BITS-1:0] to_vertex;
    logic                   both_ways;
    logic [VALUE_BITS-1:0]  new_value;
  } req_t;

  typedef struct packed {
    logic                   ok;
    logic [VALUE_BITS-1:0]  read_value;
    logic                   found;
    logic [VERTEX_BITS-1:0] listed_vertex;
    logic [COUNT_BITS-1:0]  edge_total;
    logic                   last;
  } rsp_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_REJECT,
    OP_WRITE,
    OP_READ,
    OP_LIST,
    OP_COUNT
  } op_t;

  typedef enum logic [1:0] {
    LIST_NEIGHBOR,
    LIST_IN,
    LIST_OUT
  } list_t;

  typedef struct packed {
    op_t                    op;
    list_t                  mode;
    logic [VERTEX_BITS-1:0] row;
    logic [VERTEX_BITS-1:0] col;
    logic [VALUE_BITS-1:0]  value;
    logic                   both;
  } cmd_t;

  // Matrix entry address, row major
  function automatic logic [ADDR_BITS-1:0] addr_of(input logic [VERTEX_BITS-1:0] r,
                                                   input logic [VERTEX_BITS-1:0] c);
    return ADDR_BITS'(int'(r) * MAX_VERTICES + int'(c));
  endfunction

endpackage

@@ src/adjacency_matrix_engine.sv @@
// Top level of the adjacency matrix engine: vertex count register, front, queue, back.
//
//   channel | signals                   | transfer when
//   --------+---------------------------+-----------------------------
//   request | req_valid, req_stall, req | req_valid && !req_stall
//   result  | rsp_valid, rsp_stall, rsp | rsp_valid && !rsp_stall
//   config  | cfg_write, cfg_data       | cfg_write
//
// Add and remove write one matrix entry, two with both_ways. List queries read
// vertex_count matrix entries, one per cycle unless the result register is
// stalled, from the single read port of the edge store.
// Reset is synchronous; it and any config write clear the store at once.
// A two-entry queue lets requests be taken while the back end is stalled
// on the result register.
module adjacency_matrix_engine import ame_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                req_valid,
  output logic                req_stall,
  input  req_t                req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rsp_t                rsp
);

  logic [VC_BITS-1:0] vertex_count;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  cmd_t               push_cmd;
  cmd_t               pop_cmd;

  // Vertex count, saturated at the matrix size
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_BITS'(MAX_VERTICES);
    end else if (cfg_write) begin
      if (int'(cfg_data) > MAX_VERTICES) vertex_count <= VC_BITS'(MAX_VERTICES);
      else                               vertex_count <= VC_BITS'(cfg_data);
    end
  end

  ame_front u_front (
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .vertex_count (vertex_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .cmd          (push_cmd)
  );

  ame_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  ame_back u_back (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_write),
    .vertex_count (vertex_count),
    .q_empty      (q_empty),
    .q_data       (pop_cmd),
    .q_pop        (q_pop),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp)
  );

endmodule

@@ src/ame_front.sv @@
// Front end: takes requests, checks ranges and turns them into commands.
module ame_front import ame_pkg::*; (
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  input  logic [VC_BITS-1:0] vertex_count,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               cmd
);

  logic f_ok;
  logic t_ok;

  assign f_ok      = VC_BITS'(req.from_vertex) < vertex_count;
  assign t_ok      = VC_BITS'(req.to_vertex) < vertex_count;
  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  // Classify the request
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_REJECT;
    cmd.mode  = LIST_OUT;
    cmd.row   = req.from_vertex;
    cmd.col   = req.to_vertex;
    cmd.both  = req.both_ways;
    cmd.value = req.new_value;
    case (req.kind)
      KIND_ADD: begin
        if (f_ok && t_ok) cmd.op = OP_WRITE;
      end
      KIND_REMOVE: begin
        cmd.value = '0;
        if (f_ok && t_ok) cmd.op = OP_WRITE;
      end
      KIND_READ: begin
        if (f_ok && t_ok) cmd.op = OP_READ;
      end
      KIND_NEIGHBOR: begin
        cmd.mode = LIST_NEIGHBOR;
        if (f_ok) cmd.op = OP_LIST;
      end
      KIND_IN: begin
        cmd.mode = LIST_IN;
        cmd.row  = req.to_vertex;
        if (t_ok) cmd.op = OP_LIST;
      end
      KIND_OUT: begin
        cmd.mode = LIST_OUT;
        if (f_ok) cmd.op = OP_LIST;
      end
      KIND_COUNT: begin
        cmd.op = OP_COUNT;
      end
      default: begin
        cmd.op = OP_REJECT;
      end
    endcase
  end

endmodule

@@ src/ame_queue.sv @@
// Two-entry command queue between front and back.
module ame_queue import ame_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = fill == 2'd2;
  assign empty    = fill == 2'd0;
  assign pop_data = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

@@ src/ame_back.sv @@
// Back end: edge store, non-empty count, command sequencer and result register.
module ame_back import ame_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic [VC_BITS-1:0] vertex_count,
  input  logic               q_empty,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_READ,
    ST_WR_APPLY,
    ST_RD_READ,
    ST_RD_DATA,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                 state;
  cmd_t                   cur;
  logic                   second;
  rsp_t                   res;
  logic [VC_BITS-1:0]     idx;
  logic [VERTEX_BITS-1:0] ridx;
  logic                   rd_pend;
  logic                   have_pend;
  logic [VERTEX_BITS-1:0] pend_v;
  logic [COUNT_BITS-1:0]  count;

  logic [VALUE_BITS-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]       entry_valid;
  logic [VALUE_BITS-1:0]  rd_data;
  logic                   rd_valid;

  logic                   rd_en;
  logic                   wr_en;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [ADDR_BITS-1:0]   edge_addr;
  logic                   out_free;
  logic                   rd_nonzero;
  logic                   match;
  logic                   consume;
  logic                   was_set;
  logic                   now_set;
  logic                   scan_done;
  logic                   rsp_load;

  // Assemble one result word
  function automatic rsp_t make_rsp(input logic                   ok,
                                    input logic [VALUE_BITS-1:0]  rv,
                                    input logic                   found,
                                    input logic [VERTEX_BITS-1:0] lv,
                                    input logic [COUNT_BITS-1:0]  total,
                                    input logic                   last);
    rsp_t r;
    r.ok            = ok;
    r.read_value    = rv;
    r.found         = found;
    r.listed_vertex = lv;
    r.edge_total    = total;
    r.last          = last;
    return r;
  endfunction

  assign out_free   = !rsp_valid || !rsp_stall;
  assign rd_nonzero = rd_valid && (rd_data != '0);
  assign edge_addr  = second ? addr_of(cur.col, cur.row) : addr_of(cur.row, cur.col);
  assign match      = rd_pend && rd_nonzero &&
                      !((cur.mode == LIST_NEIGHBOR) && (ridx == cur.row));
  // A returned scan entry is used up unless it must wait for the result register
  assign consume    = rd_pend && (!match || !have_pend || out_free);
  assign was_set    = rd_nonzero;
  assign now_set    = cur.value != '0;
  assign wr_en      = state == ST_WR_APPLY;
  assign scan_done  = !rd_pend && (idx == vertex_count) && out_free;
  // Result register loads a new transfer this cycle
  assign rsp_load   = ((state == ST_SCAN) && ((consume && match && have_pend) || scan_done)) ||
                      ((state == ST_FINISH) && out_free);

  // Read requests and queue pop
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = edge_addr;
    q_pop   = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop = !q_empty;
      end
      ST_WR_READ, ST_RD_READ: begin
        rd_en = 1'b1;
      end
      ST_SCAN: begin
        if (cur.mode == LIST_IN) rd_addr = addr_of(idx[VERTEX_BITS-1:0], cur.row);
        else                     rd_addr = addr_of(cur.row, idx[VERTEX_BITS-1:0]);
        rd_en = (!rd_pend || consume) && (idx != vertex_count);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Edge store with registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= entry_valid[rd_addr];
    end
    if (wr_en) mem[edge_addr] <= cur.value;
  end

  // Written marks and running non-empty count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      entry_valid <= '0;
      count       <= '0;
    end else if (wr_en) begin
      entry_valid[edge_addr] <= 1'b1;
      if (was_set && !now_set)      count <= count - COUNT_BITS'(1);
      else if (!was_set && now_set) count <= count + COUNT_BITS'(1);
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      have_pend <= 1'b0;
      second    <= 1'b0;
      idx       <= '0;
    end else begin
      if (rsp_load)        rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur       <= q_data;
            second    <= 1'b0;
            res       <= make_rsp(q_data.op == OP_COUNT, '0, 1'b0, '0,
                                  (q_data.op == OP_COUNT) ? count : '0, 1'b1);
            idx       <= '0;
            rd_pend   <= 1'b0;
            have_pend <= 1'b0;
            case (q_data.op)
              OP_WRITE: state <= ST_WR_READ;
              OP_READ:  state <= ST_RD_READ;
              OP_LIST:  state <= ST_SCAN;
              OP_COUNT: state <= ST_FINISH;
              default:  state <= ST_FINISH;
            endcase
          end
        end
        ST_WR_READ: begin
          state <= ST_WR_APPLY;
        end
        ST_WR_APPLY: begin
          if (cur.both && !second) begin
            second <= 1'b1;
            state  <= ST_WR_READ;
          end else begin
            res.ok <= 1'b1;
            state  <= ST_FINISH;
          end
        end
        ST_RD_READ: begin
          state <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          res   <= make_rsp(1'b1, rd_valid ? rd_data : '0, 1'b0, '0, '0, 1'b1);
          state <= ST_FINISH;
        end
        ST_SCAN: begin
          if (rd_en) begin
            ridx <= idx[VERTEX_BITS-1:0];
            idx  <= idx + VC_BITS'(1);
          end
          rd_pend <= rd_en || (rd_pend && !consume);
          // A new match releases the one held before it
          if (consume && match) begin
            if (have_pend) rsp <= make_rsp(1'b1, '0, 1'b1, pend_v, '0, 1'b0);
            pend_v    <= ridx;
            have_pend <= 1'b1;
          end
          // Scan done: close the list
          if (scan_done) begin
            rsp   <= make_rsp(1'b1, '0, have_pend, have_pend ? pend_v : '0, '0, 1'b1);
            state <= ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            rsp   <= res;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
